// File: design/wfs_pkg.sv
package wfs_pkg;

  typedef enum logic [1:0] {
    FUNC_LOAD = 2'd0,
    FUNC_READ = 2'd1,
    FUNC_STEP = 2'd2,
    FUNC_NOP  = 2'd3
  } func_e;

  typedef enum logic [0:0] {
    CFG_STEP_SCALE = 1'd0,
    CFG_ACTIVE_LEN = 1'd1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_READ,
    ST_PRIME,
    ST_RUN,
    ST_TAIL,
    ST_DONE
  } state_e;

  localparam int unsigned InWidth    = 18;
  localparam int unsigned VelWidth   = 16;
  localparam int unsigned ScaleWidth = 16;
  localparam int unsigned LenWidth   = 11;
  localparam int unsigned IdxWidth   = 10;
  localparam int unsigned CntWidth   = 16;
  localparam int unsigned CfgIdxW    = 1;

endpackage

// File: design/wave_1d_fdtd_stepper_unit.sv
// Leapfrog stepper for the 1D wave equation. After reset the block sweeps
// all GRID_POINTS entries of its three memories to zero, with busy high.
// Write configuration only between requests, while busy is low and no
// result is still due. A load request raises its registered result strobe
// from ST_READ, a read request from ST_DONE, after ST_READ. A step request
// walks the active grid through a small pipeline fed by one read port per
// memory, one grid point per cycle, then waits in ST_TAIL until the pipeline
// is empty before its strobe; the single read port of the field memory sets
// this rate. busy drops with the strobe, so the next request can be taken
// while the strobe is high. Exactly one result strobe (done_o) follows every
// request; results cannot be stalled.
module wave_1d_fdtd_stepper_unit #(
  parameter int unsigned GRID_POINTS = 1024,
  parameter int unsigned VALUE_BITS  = 18
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                cfg_we_i,
  input  logic [wfs_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [wfs_pkg::ScaleWidth-1:0]      cfg_data_i,
  input  logic [1:0]                          func_i,
  input  logic [wfs_pkg::IdxWidth-1:0]        index_i,
  input  logic signed [wfs_pkg::InWidth-1:0]  u_now_in_i,
  input  logic signed [wfs_pkg::InWidth-1:0]  u_prev_in_i,
  input  logic [wfs_pkg::VelWidth-1:0]        vel_sq_in_i,
  output logic                                done_o,
  output logic signed [wfs_pkg::InWidth-1:0]  value_o,
  output logic [wfs_pkg::CntWidth-1:0]        steps_done_o,
  output logic                                saturated_o
);
  import wfs_pkg::*;

  localparam int unsigned AW = (GRID_POINTS > 1) ? $clog2(GRID_POINTS) : 1;
  localparam int unsigned PW = AW + 1;
  localparam int unsigned VB = VALUE_BITS;
  localparam int unsigned LW = VB + 3;
  localparam int unsigned PRW = LW + 17;
  localparam logic signed [VB-1:0] VMax = {1'b0, {(VB-1){1'b1}}};
  localparam logic signed [VB-1:0] VMin = {1'b1, {(VB-1){1'b0}}};
  localparam logic [PW-1:0] GridP = PW'(GRID_POINTS);

  logic signed [VB-1:0] now_mem  [GRID_POINTS];
  logic signed [VB-1:0] prev_mem [GRID_POINTS];
  logic [VelWidth-1:0]  vel_mem  [GRID_POINTS];

  state_e state_q, state_d;
  logic [ScaleWidth-1:0] scale_q;
  logic [LenWidth-1:0]   alen_q;
  logic [CntWidth-1:0]   cnt_q, cnt_d;
  logic                  sat_q, sat_d, hit_q, hit_d;
  logic [1:0]            func_q;
  logic [PW-1:0]         idx_q;
  logic signed [VB-1:0]  unow_q, uprev_q;
  logic [VelWidth-1:0]   vel_q;
  logic [PW-1:0]         rd_ptr_q, rd_ptr_d, n_q;
  logic signed [VB-1:0]  value_q, value_d;
  logic                  done_q, done_d;

  // pipeline: now read returns the point for address rd_ptr-1 of last cycle
  logic signed [VB-1:0]  now_rd, prev_rd;
  logic [VelWidth-1:0]   vel_rd;
  logic                  rv_q;          // read data valid
  logic [PW-1:0]         rpos_q;        // position of read data
  logic signed [VB-1:0]  left_q, cen_q, prv_c_q;
  logic [VelWidth-1:0]   vel_c_q;
  logic [PW-1:0]         cpos_q;
  logic                  cv_q;
  // stage 2 registered
  logic signed [LW-1:0]  lap_q;
  logic [ScaleWidth-1:0] k_q;
  logic signed [LW-1:0]  base_q;
  logic [PW-1:0]         s2pos_q;
  logic                  s2v_q, s2int_q;
  logic signed [VB-1:0]  s2c_q;
  logic signed [PRW-1:0] prod_q;
  logic signed [LW-1:0]  base3_q;
  logic [PW-1:0]         s3pos_q;
  logic                  s3v_q, s3int_q;
  logic signed [VB-1:0]  s3c_q;

  logic [PW-1:0] n_eff;
  always_comb begin
    if (int'(alen_q) < 3) begin
      n_eff = PW'(3);
    end else if (int'(alen_q) > int'(GRID_POINTS)) begin
      n_eff = GridP;
    end else begin
      n_eff = PW'(alen_q);
    end
  end

  // write port arbitration
  logic                  we;
  logic [AW-1:0]         wa;
  logic signed [VB-1:0]  wnow, wprev;
  logic                  wvel_en;
  logic [VelWidth-1:0]   wvel;

  // stage 3 result
  logic signed [PRW-1:0] shifted;
  logic signed [PRW-1:0] nv;
  logic signed [VB-1:0]  nv_sat;
  logic                  nv_hit;
  always_comb begin
    shifted = prod_q >>> 15;
    nv = shifted + PRW'(base3_q);
    nv_hit = 1'b0;
    nv_sat = nv[VB-1:0];
    if (nv > PRW'(VMax)) begin nv_sat = VMax; nv_hit = 1'b1; end
    else if (nv < PRW'(VMin)) begin nv_sat = VMin; nv_hit = 1'b1; end
    if (!s3int_q) begin nv_sat = '0; nv_hit = 1'b0; end
  end

  logic signed [VB-1:0] ld_now, ld_prev;
  always_comb begin
    ld_now = unow_q;
    ld_prev = uprev_q;
  end

  always_comb begin
    state_d  = state_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    sat_d    = sat_q;
    hit_d    = hit_q;
    value_d  = value_q;
    done_d   = 1'b0;
    we = 1'b0; wa = '0; wnow = '0; wprev = '0; wvel_en = 1'b0; wvel = '0;
    if (s3v_q) begin
      we = 1'b1; wa = s3pos_q[AW-1:0]; wnow = nv_sat; wprev = s3c_q;
      hit_d = hit_q | nv_hit;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_READ;
      end
      ST_CLEAR: begin
        we = 1'b1; wa = rd_ptr_q[AW-1:0]; wvel_en = 1'b1;
        rd_ptr_d = rd_ptr_q + 1'b1;
        if (rd_ptr_q == GridP - 1'b1) state_d = ST_IDLE;
      end
      ST_READ: begin
        unique case (func_q)
          FUNC_LOAD: begin
            if (idx_q < GridP) begin
              we = 1'b1; wa = idx_q[AW-1:0]; wnow = ld_now; wprev = ld_prev;
              wvel_en = 1'b1; wvel = vel_q;
            end
            value_d = '0; done_d = 1'b1; state_d = ST_IDLE;
          end
          FUNC_READ: state_d = ST_DONE;
          FUNC_STEP: begin
            rd_ptr_d = '0; hit_d = 1'b0; state_d = ST_RUN;
          end
          default: begin value_d = '0; done_d = 1'b1; state_d = ST_IDLE; end
        endcase
      end
      ST_RUN: begin
        rd_ptr_d = rd_ptr_q + 1'b1;
        if (rd_ptr_q == n_q - 1'b1) state_d = ST_TAIL;
      end
      ST_TAIL: begin
        if (!rv_q && !cv_q && !s2v_q && !s3v_q && !(s3v_q)) begin
          cnt_d = cnt_q + 1'b1;
          sat_d = hit_q;
          value_d = '0; done_d = 1'b1; state_d = ST_IDLE;
        end
      end
      ST_DONE: begin
        value_d = (idx_q < GridP) ? now_rd : '0;
        done_d = 1'b1; state_d = ST_IDLE;
      end
      ST_PRIME: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  logic [AW-1:0] ra;
  always_comb begin
    ra = rd_ptr_q[AW-1:0];
    if (state_q == ST_READ) ra = idx_q[AW-1:0];
  end

  // memories: read old value before write in same cycle
  always_ff @(posedge clk_i) begin
    now_rd  <= now_mem[ra];
    prev_rd <= prev_mem[ra];
    vel_rd  <= vel_mem[ra];
    if (we) begin
      now_mem[wa]  <= wnow;
      prev_mem[wa] <= wprev;
    end
    if (wvel_en) vel_mem[wa] <= wvel;
  end

  // datapath
  logic signed [LW-1:0] lap_d;
  logic [31:0] kfull;
  always_comb begin
    lap_d = LW'(now_rd) - (LW'(cen_q) <<< 1) + LW'(left_q);
    kfull = 32'(scale_q) * 32'(vel_c_q);
  end

  always_ff @(posedge clk_i) begin
    if (rv_q) begin
      left_q <= cen_q; cen_q <= now_rd; prv_c_q <= prev_rd; vel_c_q <= vel_rd;
      cpos_q <= rpos_q;
    end
    lap_q   <= lap_d;
    k_q     <= kfull[31:16];
    base_q  <= (LW'(cen_q) <<< 1) - LW'(prv_c_q);
    s2pos_q <= cpos_q;
    s2c_q   <= cen_q;
    s2int_q <= (cpos_q != '0) && (cpos_q != n_q - 1'b1);
    prod_q  <= PRW'(lap_q) * PRW'($signed({1'b0, k_q}));
    base3_q <= base_q;
    s3pos_q <= s2pos_q;
    s3c_q   <= s2c_q;
    s3int_q <= s2int_q;
    if (state_q == ST_IDLE && start) begin
      func_q <= func_i; idx_q <= PW'(index_i);
      unow_q <= VB'(u_now_in_i); uprev_q <= VB'(u_prev_in_i); vel_q <= vel_sq_in_i;
      if (VB < InWidth) begin
        if (u_now_in_i > InWidth'(VMax)) unow_q <= VMax;
        else if (u_now_in_i < InWidth'(VMin)) unow_q <= VMin;
        if (u_prev_in_i > InWidth'(VMax)) uprev_q <= VMax;
        else if (u_prev_in_i < InWidth'(VMin)) uprev_q <= VMin;
      end
      n_q <= n_eff;
    end
  end

  // valid chain: read data is valid the cycle after ST_RUN issued it;
  // the center stage holds a point once it is loaded, so every point
  // including both ends passes the pipeline exactly once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR; rd_ptr_q <= '0; cnt_q <= '0; sat_q <= 1'b0; hit_q <= 1'b0;
      scale_q <= ScaleWidth'(16384); alen_q <= LenWidth'(1024);
      value_q <= '0; done_q <= 1'b0;
      rv_q <= 1'b0; rpos_q <= '0; cv_q <= 1'b0; s2v_q <= 1'b0; s3v_q <= 1'b0;
    end else begin
      state_q <= state_d; rd_ptr_q <= rd_ptr_d; cnt_q <= cnt_d; sat_q <= sat_d;
      hit_q <= hit_d; value_q <= value_d; done_q <= done_d;
      rv_q <= (state_q == ST_RUN);
      rpos_q <= rd_ptr_q;
      // lap of a center is formed while the right neighbor is on the read
      // port; the last point sees a dummy right and is forced to zero
      cv_q <= rv_q;
      s2v_q <= cv_q;
      s3v_q <= s2v_q;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_STEP_SCALE: scale_q <= cfg_data_i;
          CFG_ACTIVE_LEN: alen_q <= cfg_data_i[LenWidth-1:0];
          default: ;
        endcase
      end
    end
  end

  assign busy = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign value_o = InWidth'(value_q);
  assign steps_done_o = cnt_q;
  assign saturated_o = sat_q;

  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("request not taken");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy || $past(state_q) != ST_IDLE) else $error("stray done");
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |-> done_q) else $error("counter moved without done");
  a_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3v_q |-> (state_q == ST_RUN || state_q == ST_TAIL)) else $error("late write");
endmodule

// File: bench/field_predict_check.sv
`timescale 1ns / 100ps
module field_predict_check (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  input  logic                                busy,
  input  logic                                cfg_we_i,
  input  logic [wfs_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [wfs_pkg::ScaleWidth-1:0]      cfg_data_i,
  input  logic [1:0]                          func_i,
  input  logic [wfs_pkg::IdxWidth-1:0]        index_i,
  input  logic signed [wfs_pkg::InWidth-1:0]  u_now_in_i,
  input  logic signed [wfs_pkg::InWidth-1:0]  u_prev_in_i,
  input  logic [wfs_pkg::VelWidth-1:0]        vel_sq_in_i,
  input  logic                                done_o,
  input  logic signed [wfs_pkg::InWidth-1:0]  value_o,
  input  logic [wfs_pkg::CntWidth-1:0]        steps_done_o,
  input  logic                                saturated_o,
  output int                                  fail_count,
  output int                                  pending
);
  import wfs_pkg::*;

  localparam int Points = 1024;
  localparam longint ValMax = 131071;
  localparam longint ValMin = -131072;

  typedef struct {
    logic signed [InWidth-1:0] value;
    logic [CntWidth-1:0]       steps;
    logic                      sat;
  } field_result_t;

  logic signed [InWidth-1:0]  field_now [Points];
  logic signed [InWidth-1:0]  field_prev [Points];
  logic [VelWidth-1:0]        vel_sq [Points];
  logic [ScaleWidth-1:0]      scale;
  logic [LenWidth-1:0]        grid_len;
  logic [CntWidth-1:0]        step_count;
  logic                       sat_flag;
  field_result_t              result_q [$];
  int                         mismatches;

  // one leapfrog step over the effective grid, old values only
  function automatic void advance_grid();
    int n;
    longint left, c, r, lap, k, nv;
    logic hit;
    n = (grid_len < 3) ? 3 : ((grid_len > Points) ? Points : int'(grid_len));
    hit = 1'b0;
    left = field_now[0];
    field_prev[0] = field_now[0];
    for (int j = 1; j + 1 < n; j++) begin
      c = field_now[j];
      r = field_now[j + 1];
      lap = r - 2 * c + left;
      k = (longint'(scale) * longint'(vel_sq[j])) >>> 16;
      nv = ((lap * k) >>> 15) + 2 * c - longint'(field_prev[j]);
      field_prev[j] = c[InWidth-1:0];
      if (nv > ValMax) begin
        nv = ValMax;
        hit = 1'b1;
      end else if (nv < ValMin) begin
        nv = ValMin;
        hit = 1'b1;
      end
      field_now[j] = nv[InWidth-1:0];
      left = c;
    end
    field_prev[n - 1] = field_now[n - 1];
    field_now[0] = '0;
    field_now[n - 1] = '0;
    sat_flag = hit;
    step_count = step_count + 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    field_result_t got, want;
    if (!rst_ni) begin
      for (int j = 0; j < Points; j++) begin
        field_now[j] = '0;
        field_prev[j] = '0;
        vel_sq[j] = '0;
      end
      scale = 16'd16384;
      grid_len = 11'd1024;
      step_count = '0;
      sat_flag = 1'b0;
      result_q.delete();
      fail_count = 0;
      mismatches = 0;
      pending = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_STEP_SCALE: scale = cfg_data_i;
          CFG_ACTIVE_LEN: grid_len = cfg_data_i[LenWidth-1:0];
          default: ;
        endcase
      end
      if (done_o) begin
        got.value = value_o;
        got.steps = steps_done_o;
        got.sat = saturated_o;
        if (result_q.size() == 0) begin
          fail_count++;
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result value=%0d steps=%0d sat=%0b",
                     $realtime, got.value, got.steps, got.sat);
        end else begin
          want = result_q.pop_front();
          if (got.value !== want.value || got.steps !== want.steps || got.sat !== want.sat) begin
            fail_count++;
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch exp value=%0d steps=%0d sat=%0b got value=%0d steps=%0d sat=%0b",
                       $realtime, want.value, want.steps, want.sat,
                       got.value, got.steps, got.sat);
          end
        end
      end
      if (start && !busy) begin
        want.value = '0;
        case (func_e'(func_i))
          FUNC_LOAD: begin
            field_now[index_i] = u_now_in_i;
            field_prev[index_i] = u_prev_in_i;
            vel_sq[index_i] = vel_sq_in_i;
          end
          FUNC_READ: want.value = field_now[index_i];
          FUNC_STEP: advance_grid();
          default: ;
        endcase
        want.steps = step_count;
        want.sat = sat_flag;
        result_q.push_back(want);
      end
      pending = result_q.size();
    end
  end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
  import wfs_pkg::*;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic                      cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]        cfg_idx_i = '0;
  logic [ScaleWidth-1:0]     cfg_data_i = '0;
  logic [1:0]                func_i = FUNC_NOP;
  logic [IdxWidth-1:0]       index_i = '0;
  logic signed [InWidth-1:0] u_now_in_i = '0;
  logic signed [InWidth-1:0] u_prev_in_i = '0;
  logic [VelWidth-1:0]       vel_sq_in_i = '0;
  logic                      done_o;
  logic signed [InWidth-1:0] value_o;
  logic [CntWidth-1:0]       steps_done_o;
  logic                      saturated_o;
  int                        fail_count;
  int                        pending;
  int                        n_sent;
  int                        burst_left;
  bit                        no_gaps;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  wave_1d_fdtd_stepper_unit dut (.*);

  field_predict_check u_check (.*);

  initial begin
    #80_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int pick_value();
    case ($urandom_range(0, 5))
      0: return 131071;
      1: return -131072;
      2: return int'($urandom_range(0, 2000)) - 1000;
      default: return int'($urandom_range(0, 262143)) - 131072;
    endcase
  endfunction

  function automatic int pick_vel();
    case ($urandom_range(0, 3))
      0: return 65535;
      1: return 0;
      default: return int'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic send(input func_e f, input int ix, input int un, input int up,
                      input int vs);
    start <= 1'b1;
    func_i <= f;
    index_i <= IdxWidth'(ix);
    u_now_in_i <= InWidth'(un);
    u_prev_in_i <= InWidth'(up);
    vel_sq_in_i <= VelWidth'(vs);
    do @(posedge clk_i); while (busy);
    n_sent++;
    if (!no_gaps) begin
      if (burst_left == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
        burst_left = $urandom_range(0, 12);
      end else begin
        burst_left--;
      end
    end
  endtask

  // hold off until every expected result has come back
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_cfg(input cfg_idx_e ix, input int data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= ix;
    cfg_data_i <= ScaleWidth'(data);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // load a grid, advance a few steps, read back, with some noise mixed in
  task automatic run_sequence(input int eff, input int max_steps);
    int n_load, ix, n_steps;
    n_load = (eff <= 40) ? eff : 12;
    for (int j = 0; j < n_load; j++) begin
      ix = (eff <= 40) ? j : int'($urandom_range(0, eff - 1));
      send(FUNC_LOAD, ix, pick_value(), pick_value(), pick_vel());
    end
    n_steps = $urandom_range(1, max_steps);
    for (int s = 0; s < n_steps; s++) begin
      send(FUNC_STEP, int'($urandom()), int'($urandom()), int'($urandom()),
           int'($urandom()));
      repeat ($urandom_range(1, 3))
        send(FUNC_READ, int'($urandom_range(0, eff - 1)), 0, 0, 0);
      if ($urandom_range(0, 4) == 0)
        send(func_e'($urandom_range(0, 3)), int'($urandom()), pick_value(),
             pick_value(), pick_vel());
    end
  endtask

  initial begin
    int eff, cfg_len;
    int cfg_scale;
    n_sent = 0;
    burst_left = 0;
    no_gaps = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes at both ends of the full grid, reset config
    send(FUNC_READ, 5, 0, 0, 0);
    send(FUNC_LOAD, 0, 131071, -131072, 65535);
    send(FUNC_LOAD, 1, 131071, -131072, 65535);
    send(FUNC_LOAD, 2, -131072, 131071, 0);
    send(FUNC_LOAD, 1022, -131072, 131071, 65535);
    send(FUNC_LOAD, 1023, 87381, -43690, 43690);
    send(FUNC_LOAD, 682, -87382, 43690, 21845);
    send(FUNC_READ, 0, 0, 0, 0);
    send(FUNC_READ, 1023, 0, 0, 0);
    send(FUNC_READ, 682, 0, 0, 0);
    send(FUNC_NOP, 1023, -1, -1, 65535);
    send(FUNC_STEP, 1023, 0, 0, 0);
    send(FUNC_READ, 0, 0, 0, 0);
    send(FUNC_READ, 1, 0, 0, 0);
    send(FUNC_READ, 2, 0, 0, 0);
    send(FUNC_READ, 1022, 0, 0, 0);
    send(FUNC_READ, 1023, 0, 0, 0);
    send(FUNC_NOP, 0, 0, 0, 0);
    send(FUNC_STEP, 0, 0, 0, 0);
    send(FUNC_READ, 1, 0, 0, 0);

    for (int p = 0; n_sent < 580; p++) begin
      drain();
      case (p % 8)
        0: begin cfg_scale = 0;     cfg_len = 0;    end
        1: begin cfg_scale = 65535; cfg_len = 3;    end
        2: begin cfg_scale = int'($urandom_range(0, 65535)); cfg_len = 2047; end
        3: begin cfg_scale = 32768; cfg_len = 2;    end
        4: begin cfg_scale = int'($urandom_range(0, 65535)); cfg_len = 1024; end
        default: begin
          cfg_scale = int'($urandom_range(0, 65535));
          cfg_len = $urandom_range(4, 40);
        end
      endcase
      write_cfg(CFG_STEP_SCALE, cfg_scale);
      write_cfg(CFG_ACTIVE_LEN, cfg_len);
      eff = (cfg_len < 3) ? 3 : ((cfg_len > 1024) ? 1024 : cfg_len);
      no_gaps = (p % 3 == 2);
      if (eff > 40) begin
        run_sequence(eff, 2);
      end else begin
        repeat ($urandom_range(2, 4)) run_sequence(eff, 6);
      end
    end

    drain();
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/wfs_pkg.sv
design/wave_1d_fdtd_stepper_unit.sv
bench/field_predict_check.sv
bench/tb_top.sv
